// File: src/vbp_pkg.sv
// Shared constants and types for the variable-width bit packer.
package vbp_pkg;

   localparam int CODE_W      = 30;
   localparam int WIDTH_W     = 5;
   localparam int MAX_WIDTH   = 30;
   localparam int RESET_WIDTH = 8;
   localparam int BYTE_W      = 8;
   localparam int PEND_W      = BYTE_W - 1;
   localparam int CNT_W       = 3;
   localparam int MAX_BYTES   = 5;
   localparam int STREAM_W    = MAX_BYTES * BYTE_W;
   localparam int PAD_W       = STREAM_W - CODE_W;
   localparam int IDX_W       = $clog2(MAX_BYTES);

   // One request's worth of output bytes, earliest byte in entry 0.
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [IDX_W:0]                   n;
      logic                             last;
   } group_type;

   typedef struct packed {
      group_type          grp;
      logic [PEND_W-1:0]  pend_bits;
      logic [CNT_W-1:0]   pend_cnt;
   } pack_result_type;

endpackage

// File: src/vbp_align.sv
// Combinational packing of one sample code behind the pending leftover bits.
module vbp_align
   import vbp_pkg::*;
(
   input  logic [WIDTH_W-1:0] sample_width,
   input  logic [CODE_W-1:0]  sample_code,
   input  logic               last_sample,
   input  logic [PEND_W-1:0]  pend_bits,
   input  logic [CNT_W-1:0]   pend_cnt,
   output pack_result_type    result
);

   logic [WIDTH_W-1:0]                 width_c;
   logic [CODE_W-1:0]                  code_m;
   logic [STREAM_W-1:0]                code_la;
   logic [STREAM_W-1:0]                stream;
   logic [CNT_W+3-1:0]                 total;
   logic [CNT_W-1:0]                   nfull;
   logic [CNT_W-1:0]                   rem;
   logic [MAX_BYTES-1:0][BYTE_W-1:0]   sb;
   logic [BYTE_W-1:0]                  partial;

   always_comb begin
      width_c = (sample_width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : sample_width;
      code_m  = sample_code & ~({CODE_W{1'b1}} << width_c);
      // Left-align the code, then slide it in right after the pending bits.
      code_la = {code_m, {PAD_W{1'b0}}} << (WIDTH_W'(MAX_WIDTH) - width_c);
      stream  = {pend_bits, {(STREAM_W-PEND_W){1'b0}}} | (code_la >> pend_cnt);
      total   = (CNT_W+3)'(pend_cnt) + (CNT_W+3)'(width_c);
      nfull   = total[CNT_W+2:3];
      rem     = total[2:0];
      for (int k = 0; k < MAX_BYTES; k++) begin
         sb[k] = stream[STREAM_W-1-BYTE_W*k -: BYTE_W];
      end
      // Everything past the valid bits is zero, so the byte after the full
      // ones is already the zero-padded partial byte.
      case (nfull)
         3'd0:    partial = sb[0];
         3'd1:    partial = sb[1];
         3'd2:    partial = sb[2];
         3'd3:    partial = sb[3];
         3'd4:    partial = sb[4];
         default: partial = '0;
      endcase

      result.grp.bytes = sb;
      result.grp.last  = last_sample;
      result.grp.n     = (IDX_W+1)'(nfull)
                         + (IDX_W+1)'(last_sample && (partial != '0));
      result.pend_bits = last_sample ? '0 : partial[BYTE_W-1:1];
      result.pend_cnt  = last_sample ? '0 : rem;
   end

endmodule

// File: src/variable_width_bit_packer.sv
// Top level of the variable-width MSB-first bit packer.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_stall    req_sample_code, req_last_sample
//   rsp       out        rsp_valid/rsp_stall    rsp_packed_byte, rsp_run_last,
//                                               rsp_stream_end
//   csr       in         csr_valid/csr_ready    csr_sample_width
//
// A request is packed in the cycle it is accepted, and its bytes are registered for output.
// One byte leaves per cycle while rsp_stall is low, so a request yields 0 to 5 bytes (up to
// 4 full bytes plus a final partial byte); the output register sets the sustained rate.
// A one-entry holding register lets the next request in while bytes still drain.
// req_stall rises only while that holding register is full.
// Synchronous reset empties both stages, clears the leftover bits and sets the width to 8.
module variable_width_bit_packer
   import vbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CODE_W-1:0]  req_sample_code,
   input  logic               req_last_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_packed_byte,
   output logic               rsp_run_last,
   output logic               rsp_stream_end,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [WIDTH_W-1:0] csr_sample_width
);

   logic [WIDTH_W-1:0] width_ff,  width_in;
   logic [PEND_W-1:0]  pend_bits_ff, pend_bits_in;
   logic [CNT_W-1:0]   pend_cnt_ff,  pend_cnt_in;
   logic               a_vld_ff, a_vld_in;
   group_type          a_grp_ff, a_grp_in;
   logic               b_vld_ff, b_vld_in;
   group_type          b_grp_ff, b_grp_in;
   logic [IDX_W-1:0]   b_idx_ff, b_idx_in;

   pack_result_type    pr;
   logic               req_acc;
   logic               rsp_acc;
   logic               b_done;
   logic               b_free;
   logic               new_grp;

   vbp_align u_align (
      .sample_width (width_ff),
      .sample_code  (req_sample_code),
      .last_sample  (req_last_sample),
      .pend_bits    (pend_bits_ff),
      .pend_cnt     (pend_cnt_ff),
      .result       (pr)
   );

   assign csr_ready = 1'b1;
   assign req_stall = a_vld_ff;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = b_vld_ff;
   assign rsp_acc   = b_vld_ff && !rsp_stall;
   assign b_done    = rsp_acc && ((IDX_W+1)'(b_idx_ff) == b_grp_ff.n - 1'b1);
   assign b_free    = !b_vld_ff || b_done;
   assign new_grp   = req_acc && (pr.grp.n != '0);

   assign rsp_packed_byte = b_grp_ff.bytes[b_idx_ff];
   assign rsp_run_last    = ((IDX_W+1)'(b_idx_ff) == b_grp_ff.n - 1'b1);
   assign rsp_stream_end  = rsp_run_last && b_grp_ff.last;

   always_comb begin
      width_in     = (csr_valid && csr_ready) ? csr_sample_width : width_ff;
      pend_bits_in = req_acc ? pr.pend_bits : pend_bits_ff;
      pend_cnt_in  = req_acc ? pr.pend_cnt  : pend_cnt_ff;

      a_vld_in = a_vld_ff;
      a_grp_in = a_grp_ff;
      b_vld_in = b_vld_ff;
      b_grp_in = b_grp_ff;
      b_idx_in = b_idx_ff;

      if (b_free) begin
         // Holding register goes first; otherwise a new group goes straight to output.
         if (a_vld_ff) begin
            b_vld_in = 1'b1;
            b_grp_in = a_grp_ff;
            b_idx_in = '0;
            a_vld_in = 1'b0;
         end else if (new_grp) begin
            b_vld_in = 1'b1;
            b_grp_in = pr.grp;
            b_idx_in = '0;
         end else begin
            b_vld_in = 1'b0;
         end
      end else begin
         if (rsp_acc) begin
            b_idx_in = b_idx_ff + 1'b1;
         end
         if (new_grp) begin
            a_vld_in = 1'b1;
            a_grp_in = pr.grp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_W'(RESET_WIDTH);
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         b_idx_ff     <= '0;
      end else begin
         width_ff     <= width_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         a_vld_ff     <= a_vld_in;
         b_vld_ff     <= b_vld_in;
         b_idx_ff     <= b_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      a_grp_ff <= a_grp_in;
      b_grp_ff <= b_grp_in;
   end

   // The holding register only fills while the output stage is busy.
   a_hold_implies_busy: assert property (@(posedge clock) disable iff (reset)
      a_vld_ff |-> b_vld_ff)
      else $error("holding register full while output stage empty");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff |-> ((b_grp_ff.n != '0) && ((IDX_W+1)'(b_idx_ff) < b_grp_ff.n)))
      else $error("output byte index outside its group");

   // Leftover bits are kept left-aligned with zeros below them.
   a_pend_aligned: assert property (@(posedge clock) disable iff (reset)
      ((pend_bits_ff << pend_cnt_ff) == '0))
      else $error("stray bits below the pending leftover bits");

   a_stall_holds_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_packed_byte)))
      else $error("stalled output byte changed");

endmodule
